@@ rtl/rfa_pkg.sv @@
// Shared types, codes and helpers for the reference-counted frame allocator.
// No dependencies; imported by rfa_table and refcounted_frame_allocator.
package rfa_pkg;

    localparam int REQ_W    = 3;
    localparam int IDX_W    = 12;
    localparam int PAGES_W  = 8;
    localparam int CNT_W    = 16;
    localparam int STATUS_W = 2;
    localparam int ADDR_W   = 24;
    localparam int TOTAL_W  = 13;
    localparam int RSV_W    = 12;
    localparam int IN_W     = 40;
    localparam int OUT_W    = 48;

    typedef enum logic [REQ_W-1:0] {
        REQ_ALLOC  = 3'd0,
        REQ_FREE   = 3'd1,
        REQ_READ   = 3'd2,
        REQ_MODIFY = 3'd3,
        REQ_INIT   = 3'd4
    } t_req;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_NO_FRAME  = 2'd1,
        ST_BAD_PAGES = 2'd2,
        ST_NOT_USED  = 2'd3
    } t_status;

    typedef enum logic {
        CFG_TOTAL    = 1'b0,
        CFG_RESERVED = 1'b1
    } t_cfg_idx;

    typedef struct packed {
        logic                    used;
        logic signed [CNT_W-1:0] count;
    } t_entry;

    localparam logic signed [CNT_W-1:0] CNT_MAX = 16'sh7fff;
    localparam logic signed [CNT_W-1:0] CNT_MIN = 16'sh8000;

    // Clamp a 17-bit signed sum to the 16-bit count range.
    function automatic logic signed [CNT_W-1:0] sat16(input logic signed [CNT_W:0] v);
        logic signed [CNT_W-1:0] r;
        if (v > 17'sd32767) begin
            r = CNT_MAX;
        end else if (v < -17'sd32768) begin
            r = CNT_MIN;
        end else begin
            r = v[CNT_W-1:0];
        end
        return r;
    endfunction

endpackage

@@ rtl/rfa_table.sv @@
// Frame table storage: used mark and count per frame, and the free-list links.
// Two single-port-write, registered-read memories; uses rfa_pkg.
module rfa_table #(
    parameter int DEPTH = 4096,
    parameter int IW    = 12,
    parameter int LW    = 13
) (
    input  logic            i_clk,
    input  logic            i_rd_en,
    input  logic [IW-1:0]   i_uc_raddr,
    output rfa_pkg::t_entry o_uc_rdata,
    input  logic            i_uc_we,
    input  logic [IW-1:0]   i_uc_waddr,
    input  rfa_pkg::t_entry i_uc_wdata,
    input  logic [IW-1:0]   i_link_raddr,
    output logic [LW-1:0]   o_link_rdata,
    input  logic            i_link_we,
    input  logic [IW-1:0]   i_link_waddr,
    input  logic [LW-1:0]   i_link_wdata
);
    import rfa_pkg::*;

    t_entry      mem_uc   [DEPTH];
    logic [LW-1:0] mem_link [DEPTH];

    t_entry      r_uc_q;
    logic [LW-1:0] r_link_q;

    always_ff @(posedge i_clk) begin
        if (i_uc_we) begin
            mem_uc[i_uc_waddr] <= i_uc_wdata;
        end
        if (i_rd_en) begin
            r_uc_q <= mem_uc[i_uc_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_link_we) begin
            mem_link[i_link_waddr] <= i_link_wdata;
        end
        if (i_rd_en) begin
            r_link_q <= mem_link[i_link_raddr];
        end
    end

    assign o_uc_rdata   = r_uc_q;
    assign o_link_rdata = r_link_q;

endmodule

@@ rtl/refcounted_frame_allocator.sv @@
// Reference-counted frame allocator: one request in, one result out.
// Each request reads memory at its input transfer; then, in the execute state, it is modified,
// written back and its result registered, and execute holds while the output is full. A new
// request is taken only back in idle. Init walks the table one frame a cycle, then holds on
// the last frame until the output is free. Reset (sync, active low) starts a clearing pass of
// used marks and counts; s_tready stays low until it ends. Config writes are taken anytime out of reset.
module refcounted_frame_allocator #(
    parameter int FRAMES      = 4096,
    parameter int FRAME_SHIFT = 12
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic                        i_cfg_index,
    input  logic [rfa_pkg::TOTAL_W-1:0] i_cfg_data,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    // req_type[2:0], frame_num[14:3], page_count[22:15], ref_delta[38:23]
    input  logic [rfa_pkg::IN_W-1:0]    s_tdata,
    output logic                        m_tvalid,
    input  logic                        m_tready,
    // status[1:0], frame_address[25:2], ref_count[41:26]
    output logic [rfa_pkg::OUT_W-1:0]   m_tdata
);
    import rfa_pkg::*;

    localparam int IW = $clog2(FRAMES);
    localparam int LW = $clog2(FRAMES + 1);
    localparam logic [LW-1:0] NIL      = LW'(FRAMES);
    localparam logic [IW-1:0] LAST_IDX = IW'(FRAMES - 1);

    typedef enum logic [1:0] {S_CLEAR, S_IDLE, S_EXEC, S_INIT} t_state;

    t_state                  r_state, n_state;
    logic [TOTAL_W-1:0]      r_total;
    logic [RSV_W-1:0]        r_reserved;
    logic [LW-1:0]           r_head, n_head;
    logic [IW-1:0]           r_cnt, n_cnt;
    logic [LW-1:0]           r_tot, n_tot;
    logic [LW-1:0]           r_res, n_res;
    t_req                    r_req;
    logic [IDX_W-1:0]        r_idx;
    logic [PAGES_W-1:0]      r_pages;
    logic signed [CNT_W-1:0] r_delta;
    logic                    r_m_valid, n_m_valid;
    t_status                 r_status, n_status;
    logic [ADDR_W-1:0]       r_addr, n_addr;
    logic signed [CNT_W-1:0] r_count, n_count;

    logic                    accept;
    logic                    out_free;
    logic                    rd_en;
    logic [IW-1:0]           uc_raddr;
    t_entry                  uc_rdata;
    logic                    uc_we;
    logic [IW-1:0]           uc_waddr;
    t_entry                  uc_wdata;
    logic [LW-1:0]           link_rdata;
    logic                    link_we;
    logic [IW-1:0]           link_waddr;
    logic [LW-1:0]           link_wdata;
    logic                    idx_ok;
    logic [IW-1:0]           idx_addr;
    logic signed [CNT_W-1:0] dec_cnt;
    logic signed [CNT_W-1:0] mod_cnt;
    logic [31:0]             tot32;
    logic [31:0]             res32;
    logic [31:0]             walk32;

    assign accept   = s_tvalid && s_tready;
    assign s_tready = (r_state == S_IDLE);
    assign out_free = !r_m_valid || m_tready;
    assign rd_en    = accept;
    assign uc_raddr = (t_req'(s_tdata[2:0]) == REQ_ALLOC) ? IW'(r_head) : IW'(s_tdata[14:3]);
    assign idx_ok   = 32'(r_idx) < 32'(FRAMES);
    assign idx_addr = IW'(r_idx);
    assign dec_cnt  = sat16({uc_rdata.count[CNT_W-1], uc_rdata.count} - 17'sd1);
    assign mod_cnt  = sat16({uc_rdata.count[CNT_W-1], uc_rdata.count}
                            + {r_delta[CNT_W-1], r_delta});
    assign walk32   = 32'(r_cnt);

    // Effective totals for init, clamped to the table size.
    always_comb begin
        tot32 = (32'(r_total) > 32'(FRAMES)) ? 32'(FRAMES) : 32'(r_total);
        res32 = (32'(r_reserved) > tot32) ? tot32 : 32'(r_reserved);
    end

    rfa_table #(
        .DEPTH (FRAMES),
        .IW    (IW),
        .LW    (LW)
    ) u_table (
        .i_clk        (i_clk),
        .i_rd_en      (rd_en),
        .i_uc_raddr   (uc_raddr),
        .o_uc_rdata   (uc_rdata),
        .i_uc_we      (uc_we),
        .i_uc_waddr   (uc_waddr),
        .i_uc_wdata   (uc_wdata),
        .i_link_raddr (IW'(r_head)),
        .o_link_rdata (link_rdata),
        .i_link_we    (link_we),
        .i_link_waddr (link_waddr),
        .i_link_wdata (link_wdata)
    );

    always_comb begin
        n_state    = r_state;
        n_head     = r_head;
        n_cnt      = r_cnt;
        n_tot      = r_tot;
        n_res      = r_res;
        n_m_valid  = r_m_valid && !m_tready;
        n_status   = r_status;
        n_addr     = r_addr;
        n_count    = r_count;
        uc_we      = 1'b0;
        uc_waddr   = idx_addr;
        uc_wdata   = uc_rdata;
        link_we    = 1'b0;
        link_waddr = idx_addr;
        link_wdata = r_head;

        unique case (r_state)
            S_CLEAR: begin
                uc_we          = 1'b1;
                uc_waddr       = r_cnt;
                uc_wdata.used  = 1'b0;
                uc_wdata.count = '0;
                n_cnt          = r_cnt + 1'b1;
                if (r_cnt == LAST_IDX) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (accept) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                if (r_req == REQ_INIT) begin
                    n_tot   = LW'(tot32);
                    n_res   = LW'(res32);
                    n_head  = (res32 < tot32) ? LW'(res32) : NIL;
                    n_cnt   = '0;
                    n_state = S_INIT;
                end else if (out_free) begin
                    n_m_valid = 1'b1;
                    n_state   = S_IDLE;
                    n_status  = ST_OK;
                    n_addr    = '0;
                    n_count   = '0;
                    priority case (r_req)
                        REQ_ALLOC: begin
                            if (r_head == NIL || uc_rdata.used) begin
                                n_status = ST_NO_FRAME;
                            end else if (r_pages != PAGES_W'(1)) begin
                                n_status = ST_BAD_PAGES;
                            end else begin
                                uc_we          = 1'b1;
                                uc_waddr       = IW'(r_head);
                                uc_wdata.used  = 1'b1;
                                uc_wdata.count = 16'sd1;
                                n_head         = link_rdata;
                                n_addr         = ADDR_W'(64'(r_head) << FRAME_SHIFT);
                                n_count        = 16'sd1;
                            end
                        end
                        REQ_FREE, REQ_READ, REQ_MODIFY: begin
                            if (!idx_ok) begin
                                n_status = ST_NOT_USED;
                            end else if (r_req == REQ_FREE) begin
                                if (!uc_rdata.used) begin
                                    n_status = ST_NOT_USED;
                                    n_count  = uc_rdata.count;
                                end else begin
                                    uc_we          = 1'b1;
                                    uc_wdata.count = dec_cnt;
                                    n_count        = dec_cnt;
                                    // Count at or below zero: push the frame onto the list
                                    if (dec_cnt <= 16'sd0) begin
                                        uc_wdata.used = 1'b0;
                                        link_we       = 1'b1;
                                        n_head        = LW'(idx_addr);
                                    end
                                end
                            end else if (r_req == REQ_MODIFY) begin
                                uc_we          = 1'b1;
                                uc_wdata.count = mod_cnt;
                                n_count        = mod_cnt;
                            end else begin
                                n_count = uc_rdata.count;
                            end
                        end
                        default: begin
                            n_status = ST_OK;
                        end
                    endcase
                end
            end
            S_INIT: begin
                uc_we          = 1'b1;
                uc_waddr       = r_cnt;
                uc_wdata.used  = walk32 < 32'(r_res);
                uc_wdata.count = (walk32 < 32'(r_res)) ? 16'sd1 : 16'sd0;
                link_we        = 1'b1;
                link_waddr     = r_cnt;
                link_wdata     = (walk32 >= 32'(r_res) && walk32 + 32'd1 < 32'(r_tot))
                                 ? LW'(walk32 + 32'd1) : NIL;
                if (r_cnt != LAST_IDX) begin
                    n_cnt = r_cnt + 1'b1;
                end else if (out_free) begin
                    // Hold on the last frame until the output register frees up
                    n_m_valid = 1'b1;
                    n_status  = ST_OK;
                    n_addr    = '0;
                    n_count   = '0;
                    n_state   = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_CLEAR;
            r_head     <= NIL;
            r_cnt      <= '0;
            r_m_valid  <= 1'b0;
            r_total    <= TOTAL_W'(4096);
            r_reserved <= RSV_W'(1);
        end else begin
            r_state   <= n_state;
            r_head    <= n_head;
            r_cnt     <= n_cnt;
            r_m_valid <= n_m_valid;
            if (i_cfg_we) begin
                unique case (t_cfg_idx'(i_cfg_index))
                    CFG_TOTAL:    r_total    <= i_cfg_data;
                    CFG_RESERVED: r_reserved <= i_cfg_data[RSV_W-1:0];
                    default:      r_total    <= r_total;
                endcase
            end
        end
    end

    // Payload registers: request fields and result
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_req   <= t_req'(s_tdata[2:0]);
            r_idx   <= s_tdata[14:3];
            r_pages <= s_tdata[22:15];
            r_delta <= s_tdata[38:23];
        end
        r_tot    <= n_tot;
        r_res    <= n_res;
        r_status <= n_status;
        r_addr   <= n_addr;
        r_count  <= n_count;
    end

    assign m_tvalid = r_m_valid;
    assign m_tdata  = {6'b0, r_count, r_addr, r_status};

`ifndef ASSERT_OFF
    a_accept_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_tvalid && s_tready) |=> (r_state == S_EXEC))
        else $error("accepted request did not enter execute");

    a_head_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (32'(r_head) <= 32'(FRAMES)))
        else $error("free-list head out of range");

    a_addr_alloc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_tvalid && r_addr != '0) |-> (r_status == ST_OK && r_count == 16'sd1))
        else $error("address returned without successful alloc");

    a_write_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (uc_we || link_we) |-> (r_state != S_IDLE))
        else $error("table written while idle");
`endif

endmodule

@@ test/refcounted_frame_allocator_tb.sv @@
// Self-checking bench for refcounted_frame_allocator: canned requests, then random phases.
// Holds its own frame table, free list and limits, and checks every reply.
// Depends on rfa_pkg and the refcounted_frame_allocator RTL.
module refcounted_frame_allocator_tb;
    import rfa_pkg::*;

    localparam int FRAMES         = 4096;
    localparam int FRAME_SHIFT    = 12;
    localparam logic [12:0] NIL_LINK = 13'd4096;
    localparam logic [REQ_W-1:0] REQ_SPARE5 = 3'd5;
    localparam logic [REQ_W-1:0] REQ_SPARE6 = 3'd6;
    localparam logic [REQ_W-1:0] REQ_SPARE7 = 3'd7;
    localparam int CYCLE_LIMIT    = 2_000_000;
    localparam int HOLD_CYCLES    = 400;
    localparam int NUM_PHASES     = 7;
    localparam int PRESSURE_PHASE = 5;

    typedef struct packed {
        logic [REQ_W-1:0]        req;
        logic [IDX_W-1:0]        idx;
        logic [PAGES_W-1:0]      pages;
        logic signed [CNT_W-1:0] delta;
    } frame_req_t;

    typedef struct packed {
        t_status                 status;
        logic [ADDR_W-1:0]       addr;
        logic signed [CNT_W-1:0] count;
    } frame_reply_t;

    typedef struct packed {
        frame_req_t   rq;
        logic         typed;
        frame_reply_t want;
    } canned_row_t;

    logic                 i_clk       = 1'b0;
    logic                 i_rst_n     = 1'b0;
    logic                 i_cfg_we    = 1'b0;
    logic                 i_cfg_index = 1'b0;
    logic [TOTAL_W-1:0]   i_cfg_data  = '0;
    logic                 s_tvalid    = 1'b0;
    logic                 s_tready;
    logic [IN_W-1:0]      s_tdata     = '0;
    logic                 m_tvalid;
    logic                 m_tready    = 1'b0;
    logic [OUT_W-1:0]     m_tdata;

    // Shadow of the frame table and the limits
    bit                      fr_used  [FRAMES];
    logic signed [CNT_W-1:0] fr_count [FRAMES] = '{default: '0};
    logic [12:0]             fr_link  [FRAMES] = '{default: '0};
    logic [12:0]             fr_head      = NIL_LINK;
    logic [TOTAL_W-1:0]      lim_total    = 13'd4096;
    logic [RSV_W-1:0]        lim_reserved = 12'd1;

    frame_reply_t  replies_due [$];
    logic [11:0]   live_frames [$];
    canned_row_t   canned [$];
    int            mismatches  = 0;
    int            cycle_count = 0;
    bit            src_gaps    = 1'b1;
    bit            snk_gaps    = 1'b1;
    bit            hold_sink   = 1'b0;

    refcounted_frame_allocator #(
        .FRAMES      (FRAMES),
        .FRAME_SHIFT (FRAME_SHIFT)
    ) uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("refcounted_frame_allocator_tb: done, errors");
            $finish;
        end
    end

    // Clamp to 16 bits: the two top bits differ only on overflow
    function automatic logic signed [CNT_W-1:0] clamp_count(input logic signed [CNT_W:0] v);
        if (v[CNT_W] != v[CNT_W-1]) begin
            return v[CNT_W] ? 16'sh8000 : 16'sh7fff;
        end
        return v[CNT_W-1:0];
    endfunction

    task automatic serve_request(input frame_req_t rq, output frame_reply_t rp);
        logic [12:0]             f;
        int                      tot;
        int                      res;
        logic signed [CNT_W:0]   sum;
        rp = '0;
        if (rq.req == REQ_ALLOC) begin
            f = fr_head;
            if (f >= NIL_LINK || fr_used[f[11:0]]) begin
                rp.status = ST_NO_FRAME;
            end else if (rq.pages != 8'd1) begin
                rp.status = ST_BAD_PAGES;
            end else begin
                fr_used[f[11:0]]  = 1'b1;
                fr_count[f[11:0]] = 16'sd1;
                fr_head           = fr_link[f[11:0]];
                rp.addr           = 24'(f[11:0]) << FRAME_SHIFT;
                rp.count          = 16'sd1;
            end
        end else if (rq.req == REQ_INIT) begin
            tot = (int'(lim_total) > FRAMES) ? FRAMES : int'(lim_total);
            res = (int'(lim_reserved) > tot) ? tot : int'(lim_reserved);
            for (int i = 0; i < FRAMES; i++) begin
                fr_used[i]  = (i < res);
                fr_count[i] = (i < res) ? 16'sd1 : 16'sd0;
                fr_link[i]  = (i >= res && i + 1 < tot) ? 13'(i + 1) : NIL_LINK;
            end
            fr_head = (res < tot) ? 13'(res) : NIL_LINK;
        end else if (rq.req > REQ_INIT) begin
            // spare codes: reply stays all zero
        end else if (rq.req == REQ_FREE && !fr_used[rq.idx]) begin
            rp.status = ST_NOT_USED;
            rp.count  = fr_count[rq.idx];
        end else begin
            if (rq.req == REQ_FREE) begin
                sum = fr_count[rq.idx] - 17'sd1;
            end else if (rq.req == REQ_MODIFY) begin
                sum = fr_count[rq.idx] + rq.delta;
            end else begin
                sum = fr_count[rq.idx];
            end
            fr_count[rq.idx] = clamp_count(sum);
            // push the frame back once its last reference is gone
            if (rq.req == REQ_FREE && fr_count[rq.idx] <= 0) begin
                fr_link[rq.idx] = fr_head;
                fr_used[rq.idx] = 1'b0;
                fr_head         = {1'b0, rq.idx};
            end
            rp.count = fr_count[rq.idx];
        end
    endtask

    function automatic frame_req_t pick_request(input int span);
        frame_req_t rq;
        int         k;
        k = $urandom_range(0, 99);
        if (k < 30)      rq.req = REQ_ALLOC;
        else if (k < 58) rq.req = REQ_FREE;
        else if (k < 68) rq.req = REQ_READ;
        else if (k < 84) rq.req = REQ_MODIFY;
        else if (k < 86) rq.req = REQ_INIT;
        else if (k < 92) rq.req = 3'($urandom_range(REQ_SPARE5, REQ_SPARE7));
        else             rq.req = REQ_FREE;
        k = $urandom_range(0, 9);
        if (k < 5 && live_frames.size() > 0) begin
            rq.idx = live_frames[$urandom_range(0, live_frames.size() - 1)];
        end else if (k < 8) begin
            rq.idx = 12'($urandom_range(0, span));
        end else begin
            rq.idx = 12'($urandom);
        end
        rq.pages = ($urandom_range(0, 9) < 8) ? 8'd1 : 8'($urandom_range(0, 255));
        k = $urandom_range(0, 9);
        if (k < 5) begin
            rq.delta = 16'($urandom_range(0, 8) + 65532);   // -4..4
        end else if (k < 7) begin
            rq.delta = $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
        end else begin
            rq.delta = 16'($urandom);
        end
        return rq;
    endfunction

    task automatic add_row(input logic [REQ_W-1:0] req, input logic [IDX_W-1:0] idx,
                           input logic [PAGES_W-1:0] pages, input logic [CNT_W-1:0] delta,
                           input logic typed, input t_status st,
                           input logic [ADDR_W-1:0] addr, input logic signed [CNT_W-1:0] cnt);
        canned_row_t row;
        row.rq.req       = req;
        row.rq.idx       = idx;
        row.rq.pages     = pages;
        row.rq.delta     = delta;
        row.typed        = typed;
        row.want.status  = st;
        row.want.addr    = addr;
        row.want.count   = cnt;
        canned.push_back(row);
    endtask

    // Offer one request after a random gap (when source gaps are on) and log its reply at the transfer
    task automatic offer(input frame_req_t rq, input logic typed, input frame_reply_t want);
        int           gap;
        frame_reply_t rp;
        gap = src_gaps ? $urandom_range(0, 7) : 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {1'b0, rq.delta, rq.pages, rq.idx, rq.req};
        do @(posedge i_clk); while (!s_tready);
        serve_request(rq, rp);
        replies_due.push_back(typed ? want : rp);
        if (rq.req == REQ_ALLOC && rp.status == ST_OK) begin
            live_frames.push_back(rp.addr[FRAME_SHIFT +: 12]);
            if (live_frames.size() > 32) void'(live_frames.pop_front());
        end
    endtask

    task automatic set_limits(input logic [TOTAL_W-1:0] total, input logic [RSV_W-1:0] reserved);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= CFG_TOTAL;
        i_cfg_data  <= total;
        @(posedge i_clk);
        i_cfg_index <= CFG_RESERVED;
        i_cfg_data  <= {1'b0, reserved};
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        lim_total    = total;
        lim_reserved = reserved;
    endtask

    initial begin : reply_sink
        int           gap;
        frame_reply_t got;
        frame_reply_t want;
        do @(posedge i_clk); while (!i_rst_n);
        forever begin
            if (hold_sink) begin
                gap       = HOLD_CYCLES;
                hold_sink = 1'b0;
            end else begin
                gap = snk_gaps ? $urandom_range(0, 7) : 0;
            end
            if (gap > 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            m_tready <= 1'b1;
            do @(posedge i_clk); while (!m_tvalid);
            got.status = t_status'(m_tdata[1:0]);
            got.addr   = m_tdata[25:2];
            got.count  = m_tdata[41:26];
            if (replies_due.size() == 0) begin
                $error("reply with none outstanding: status %0d addr %0h count %0d",
                       got.status, got.addr, got.count);
                mismatches++;
            end else begin
                want = replies_due.pop_front();
                if (got.status !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, got.status);
                    mismatches++;
                end
                if (got.addr !== want.addr) begin
                    $error("frame_address: expected %0h, got %0h", want.addr, got.addr);
                    mismatches++;
                end
                if (got.count !== want.count) begin
                    $error("ref_count: expected %0d, got %0d", want.count, got.count);
                    mismatches++;
                end
            end
        end
    end

    initial begin : stimulus
        int           ph_total [NUM_PHASES] = '{2, 8, 8191, 16, 4096, 12, 33};
        int           ph_rsv   [NUM_PHASES] = '{1, 3, 4095, 20, 0, 1, 2};
        int           ph_items [NUM_PHASES] = '{110, 150, 60, 80, 230, 200, 270};
        int           ph_gaps  [NUM_PHASES] = '{3, 3, 0, 1, 2, 2, 3};
        frame_reply_t none;
        frame_req_t   rq;
        int           done_items;
        int           span;

        none = '0;
        // before init: empty list, nothing used, cleared table
        add_row(REQ_ALLOC,  12'd0,    8'd1,   16'h0000, 1, ST_NO_FRAME,  24'h0, 16'sd0);
        add_row(REQ_FREE,   12'd5,    8'd1,   16'h0000, 1, ST_NOT_USED,  24'h0, 16'sd0);
        add_row(REQ_READ,   12'd4095, 8'd0,   16'h0000, 1, ST_OK,        24'h0, 16'sd0);
        add_row(REQ_MODIFY, 12'd4095, 8'd0,   16'h7fff, 1, ST_OK,        24'h0, 16'sd32767);
        add_row(REQ_MODIFY, 12'd4095, 8'd0,   16'h7fff, 1, ST_OK,        24'h0, 16'sd32767);
        add_row(REQ_MODIFY, 12'd4095, 8'd0,   16'h8000, 1, ST_OK,        24'h0, -16'sd1);
        add_row(REQ_MODIFY, 12'd4095, 8'd0,   16'h8000, 1, ST_OK,        24'h0, -16'sd32768);
        add_row(REQ_SPARE5, 12'd4095, 8'd255, 16'hffff, 1, ST_OK,        24'h0, 16'sd0);
        add_row(REQ_SPARE7, 12'd0,    8'd0,   16'h0000, 1, ST_OK,        24'h0, 16'sd0);
        add_row(REQ_INIT,   12'd0,    8'd0,   16'h0000, 1, ST_OK,        24'h0, 16'sd0);
        add_row(REQ_READ,   12'd4095, 8'd0,   16'h0000, 1, ST_OK,        24'h0, 16'sd0);
        add_row(REQ_ALLOC,  12'd0,    8'd0,   16'h0000, 1, ST_BAD_PAGES, 24'h0, 16'sd0);
        add_row(REQ_ALLOC,  12'd0,    8'd255, 16'h0000, 1, ST_BAD_PAGES, 24'h0, 16'sd0);
        add_row(REQ_ALLOC,  12'd0,    8'd1,   16'h0000, 1, ST_OK,   24'h001000, 16'sd1);
        add_row(REQ_ALLOC,  12'd0,    8'd1,   16'h0000, 1, ST_OK,   24'h002000, 16'sd1);
        add_row(REQ_READ,   12'd1,    8'd0,   16'h0000, 0, ST_OK,        24'h0, 16'sd0);
        add_row(REQ_MODIFY, 12'd1,    8'd0,   16'h0002, 0, ST_OK,        24'h0, 16'sd0);
        add_row(REQ_FREE,   12'd1,    8'd0,   16'h0000, 0, ST_OK,        24'h0, 16'sd0);
        add_row(REQ_FREE,   12'd1,    8'd0,   16'h0000, 0, ST_OK,        24'h0, 16'sd0);
        add_row(REQ_FREE,   12'd1,    8'd0,   16'h0000, 0, ST_OK,        24'h0, 16'sd0);
        add_row(REQ_FREE,   12'd1,    8'd0,   16'h0000, 1, ST_NOT_USED,  24'h0, 16'sd0);
        add_row(REQ_ALLOC,  12'd0,    8'd1,   16'h0000, 0, ST_OK,        24'h0, 16'sd0);
        // a reserved frame goes back on the list; frame 0 then yields address 0
        add_row(REQ_FREE,   12'd0,    8'd0,   16'h0000, 1, ST_OK,        24'h0, 16'sd0);
        add_row(REQ_ALLOC,  12'd0,    8'd1,   16'h0000, 1, ST_OK,        24'h0, 16'sd1);
        add_row(REQ_MODIFY, 12'd2,    8'd0,   16'h8000, 0, ST_OK,        24'h0, 16'sd0);
        add_row(REQ_FREE,   12'd2,    8'd0,   16'h0000, 0, ST_OK,        24'h0, 16'sd0);
        add_row(REQ_SPARE6, 12'd2,    8'd1,   16'h0001, 1, ST_OK,        24'h0, 16'sd0);

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (canned[i]) offer(canned[i].rq, canned[i].typed, canned[i].want);

        for (int p = 0; p < NUM_PHASES; p++) begin
            s_tvalid <= 1'b0;
            while (replies_due.size() != 0) @(posedge i_clk);
            repeat (4) @(posedge i_clk);
            set_limits(13'(ph_total[p]), 12'(ph_rsv[p]));
            src_gaps = ph_gaps[p][0];
            snk_gaps = ph_gaps[p][1];
            live_frames.delete();
            rq     = '0;
            rq.req = REQ_INIT;
            offer(rq, 1'b0, none);
            span = (ph_total[p] > FRAMES) ? FRAMES : ph_total[p];
            span = (span + 2 > FRAMES - 1) ? FRAMES - 1 : span + 2;
            done_items = 0;
            while (done_items < ph_items[p]) begin
                rq = pick_request(span);
                offer(rq, 1'b0, none);
                if (rq.req <= REQ_INIT) begin
                    done_items++;
                    // stall the output long enough to back up the input
                    if (p == PRESSURE_PHASE && done_items == 20) hold_sink = 1'b1;
                end
            end
        end
        s_tvalid <= 1'b0;

        while (replies_due.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("refcounted_frame_allocator_tb: done, clean");
        end else begin
            $display("refcounted_frame_allocator_tb: done, errors");
        end
        $finish;
    end

endmodule
